@@ design/sbf_pkg.sv @@
// types, constants and stage counts for the spring bond force pipeline
// no dependencies; imported by every module of the block
package sbf_pkg;

    localparam int POS_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int MAG_W   = 32;
    localparam int REST_W  = 31;
    localparam int MASS_W  = 32;
    localparam int K_W     = 32;
    localparam int RAD_W   = 66;
    localparam int ROOT_W  = 33;
    localparam int REM_W   = 35;
    localparam int X_W     = 35;
    localparam int XMAG_W  = 34;
    localparam int KX_W    = 66;
    localparam int HALF_W  = 33;
    localparam int PP_W    = 65;
    localparam int NUM_W   = 98;
    localparam int DEN_W   = 65;
    localparam int QUO_W   = 32;
    localparam int LANES   = 6;

    localparam int FRONT_STAGES = 4;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int FORCE_STAGES = 4;
    localparam int DIV_STAGES   = QUO_W + 1;
    localparam int OUT_STAGES   = 1;
    localparam int PIPE_LAT     = FRONT_STAGES + SQRT_STAGES + FORCE_STAGES
                                  + DIV_STAGES + OUT_STAGES;

    localparam logic [K_W-1:0] K_RESET = 32'd262144;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_LEN  = 2'd1;
    localparam logic [1:0] ST_ZERO_MASS = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_a_x;
        logic signed [POS_W-1:0] pos_a_y;
        logic signed [POS_W-1:0] pos_a_z;
        logic signed [POS_W-1:0] pos_b_x;
        logic signed [POS_W-1:0] pos_b_y;
        logic signed [POS_W-1:0] pos_b_z;
        logic [REST_W-1:0]       rest_length;
        logic [MASS_W-1:0]       mass_a;
        logic [MASS_W-1:0]       mass_b;
        logic                    fixed_a;
        logic                    fixed_b;
    } bond_t;

    typedef struct packed {
        logic signed [POS_W-1:0] dva_x;
        logic signed [POS_W-1:0] dva_y;
        logic signed [POS_W-1:0] dva_z;
        logic signed [POS_W-1:0] dvb_x;
        logic signed [POS_W-1:0] dvb_y;
        logic signed [POS_W-1:0] dvb_z;
        logic [1:0]              status;
    } result_t;

    typedef struct packed {
        logic [REST_W-1:0] rest;
        logic [MASS_W-1:0] mass_a;
        logic [MASS_W-1:0] mass_b;
        logic              fixed_a;
        logic              fixed_b;
    } meta_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] dmag;
        logic [2:0]            dneg;
        meta_t                 meta;
    } side_t;

    typedef struct packed {
        logic [2:0] dneg;
        logic       xneg;
        logic       zero_len;
        logic       fixed_a;
        logic       fixed_b;
        logic       mass_a_zero;
        logic       mass_b_zero;
    } tag_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [DEN_W-1:0]      den_a;
        logic [DEN_W-1:0]      den_b;
        tag_t                  tag;
    } force_t;

    typedef struct packed {
        logic [LANES-1:0]             ovf;
        logic [LANES-1:0][QUO_W-1:0] quo;
        tag_t                         tag;
    } quot_t;

endpackage

@@ design/sbf_front.sv @@
// front stages: separation vector, magnitudes, squares and their sum
// depends on sbf_pkg
module sbf_front
    import sbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bond_t             bond,
    output logic              out_valid,
    output logic [RAD_W-1:0]  rad,
    output side_t             side
);

    logic [FRONT_STAGES-1:0] valid_reg;

    logic signed [DIFF_W-1:0] diff_reg [3];
    logic signed [DIFF_W-1:0] diff_next [3];
    meta_t                    meta1_reg;
    side_t                    side2_reg, side2_next;
    logic [2*MAG_W-1:0]       sq_reg [3];
    logic [2*MAG_W-1:0]       sq_next [3];
    side_t                    side3_reg;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    side_t                    side4_reg;

    always_comb
    begin
        diff_next[0] = $signed({bond.pos_b_x[POS_W-1], bond.pos_b_x})
                     - $signed({bond.pos_a_x[POS_W-1], bond.pos_a_x});
        diff_next[1] = $signed({bond.pos_b_y[POS_W-1], bond.pos_b_y})
                     - $signed({bond.pos_a_y[POS_W-1], bond.pos_a_y});
        diff_next[2] = $signed({bond.pos_b_z[POS_W-1], bond.pos_b_z})
                     - $signed({bond.pos_a_z[POS_W-1], bond.pos_a_z});
    end

    always_comb
    begin
        logic [DIFF_W-1:0] neg_val;
        side2_next.meta = meta1_reg;
        for (int i = 0; i < 3; i++)
        begin
            neg_val = DIFF_W'(-diff_reg[i]);
            side2_next.dneg[i] = diff_reg[i][DIFF_W-1];
            side2_next.dmag[i] = diff_reg[i][DIFF_W-1] ? neg_val[MAG_W-1:0]
                                                      : diff_reg[i][MAG_W-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = side2_reg.dmag[i] * side2_reg.dmag[i];
        end
    end

    always_comb
    begin
        rad_next = RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_reg[i] <= diff_next[i];
            sq_reg[i]   <= sq_next[i];
        end
        meta1_reg.rest    <= bond.rest_length;
        meta1_reg.mass_a  <= bond.mass_a;
        meta1_reg.mass_b  <= bond.mass_b;
        meta1_reg.fixed_a <= bond.fixed_a;
        meta1_reg.fixed_b <= bond.fixed_b;
        side2_reg         <= side2_next;
        side3_reg         <= side2_reg;
        rad_reg           <= rad_next;
        side4_reg         <= side3_reg;
    end

    assign out_valid = valid_reg[FRONT_STAGES-1];
    assign rad       = rad_reg;
    assign side      = side4_reg;

endmodule

@@ design/sbf_sqrt.sv @@
// pipelined integer square root, one root bit per stage
// depends on sbf_pkg
module sbf_sqrt
    import sbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad,
    input  side_t             side_in,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output side_t             side_out
);

    logic [SQRT_STAGES-1:0] valid_reg;
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [REM_W-1:0]  rem_next [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_next [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_reg  [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_next [SQRT_STAGES];
    side_t             side_reg [SQRT_STAGES];

    always_comb
    begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W+1:0]  acc;
        logic [REM_W+1:0]  trial;
        for (int i = 0; i < SQRT_STAGES; i++)
        begin
            if (i == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = rad;
            end
            else
            begin
                rem_in  = rem_reg[i-1];
                root_in = root_reg[i-1];
                rad_in  = rad_reg[i-1];
            end
            acc   = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (acc >= trial)
            begin
                rem_next[i]  = REM_W'(acc - trial);
                root_next[i] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = acc[REM_W-1:0];
                root_next[i] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[i] = {rad_in[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SQRT_STAGES; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            root_reg[i] <= root_next[i];
            rad_reg[i]  <= rad_next[i];
            side_reg[i] <= (i == 0) ? side_in : side_reg[i-1];
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign root      = root_reg[SQRT_STAGES-1];
    assign side_out  = side_reg[SQRT_STAGES-1];

endmodule

@@ design/sbf_force.sv @@
// extension, stiffness product, denominators and split numerator products
// depends on sbf_pkg
module sbf_force
    import sbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] len,
    input  side_t             side,
    input  logic [K_W-1:0]    kspring,
    output logic              out_valid,
    output force_t            force_out
);

    logic [FORCE_STAGES-1:0] valid_reg;

    // stage 1
    logic [XMAG_W-1:0] xmag_reg, xmag_next;
    logic              xneg_reg, xneg_next;
    logic [ROOT_W-1:0] len_reg;
    side_t             side1_reg;
    // stage 2
    logic [KX_W-1:0]   kx_reg, kx_next;
    logic [DEN_W-1:0]  den_a2_reg, den_a2_next;
    logic [DEN_W-1:0]  den_b2_reg, den_b2_next;
    logic [2:0][MAG_W-1:0] dmag2_reg;
    tag_t              tag2_reg, tag2_next;
    // stage 3
    logic [PP_W-1:0]   pp_lo_reg [3];
    logic [PP_W-1:0]   pp_lo_next [3];
    logic [PP_W-1:0]   pp_hi_reg [3];
    logic [PP_W-1:0]   pp_hi_next [3];
    logic [DEN_W-1:0]  den_a3_reg, den_b3_reg;
    tag_t              tag3_reg;
    // stage 4
    force_t            force_reg, force_next;

    always_comb
    begin
        logic signed [X_W-1:0] x;
        logic [X_W-1:0]        neg_val;
        x         = $signed({2'b00, len}) - $signed({4'b0000, side.meta.rest});
        neg_val   = X_W'(-x);
        xneg_next = x[X_W-1];
        xmag_next = x[X_W-1] ? neg_val[XMAG_W-1:0] : x[XMAG_W-1:0];
    end

    always_comb
    begin
        kx_next               = kspring * xmag_reg;
        den_a2_next           = len_reg * side1_reg.meta.mass_a;
        den_b2_next           = len_reg * side1_reg.meta.mass_b;
        tag2_next.dneg        = side1_reg.dneg;
        tag2_next.xneg        = xneg_reg;
        tag2_next.zero_len    = (len_reg == '0);
        tag2_next.fixed_a     = side1_reg.meta.fixed_a;
        tag2_next.fixed_b     = side1_reg.meta.fixed_b;
        tag2_next.mass_a_zero = (side1_reg.meta.mass_a == '0);
        tag2_next.mass_b_zero = (side1_reg.meta.mass_b == '0);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pp_lo_next[i] = kx_reg[HALF_W-1:0] * dmag2_reg[i];
            pp_hi_next[i] = kx_reg[KX_W-1:HALF_W] * dmag2_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            force_next.num[i] = {pp_hi_reg[i], {HALF_W{1'b0}}}
                              + {{HALF_W{1'b0}}, pp_lo_reg[i]};
        end
        force_next.den_a = den_a3_reg;
        force_next.den_b = den_b3_reg;
        force_next.tag   = tag3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FORCE_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        xmag_reg   <= xmag_next;
        xneg_reg   <= xneg_next;
        len_reg    <= len;
        side1_reg  <= side;
        kx_reg     <= kx_next;
        den_a2_reg <= den_a2_next;
        den_b2_reg <= den_b2_next;
        dmag2_reg  <= side1_reg.dmag;
        tag2_reg   <= tag2_next;
        for (int i = 0; i < 3; i++)
        begin
            pp_lo_reg[i] <= pp_lo_next[i];
            pp_hi_reg[i] <= pp_hi_next[i];
        end
        den_a3_reg <= den_a2_reg;
        den_b3_reg <= den_b2_reg;
        tag3_reg   <= tag2_reg;
        force_reg  <= force_next;
    end

    assign out_valid = valid_reg[FORCE_STAGES-1];
    assign force_out = force_reg;

endmodule

@@ design/sbf_div.sv @@
// six-lane pipelined restoring divider, overflow check then one quotient bit per stage
// depends on sbf_pkg
module sbf_div
    import sbf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  force_t force_in,
    output logic   out_valid,
    output quot_t  quot
);

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DEN_W-1:0] rem_reg  [DIV_STAGES][LANES];
    logic [DEN_W-1:0] rem_next [DIV_STAGES][LANES];
    logic [QUO_W-1:0] low_reg  [DIV_STAGES][LANES];
    logic [QUO_W-1:0] low_next [DIV_STAGES][LANES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES][LANES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES][LANES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES][LANES];
    logic [DEN_W-1:0] den_next [DIV_STAGES][LANES];
    logic             ovf_reg  [DIV_STAGES][LANES];
    logic             ovf_next [DIV_STAGES][LANES];
    tag_t             tag_reg  [DIV_STAGES];

    always_comb
    begin
        logic [NUM_W-1:0] n;
        logic [DEN_W-1:0] d;
        logic [DEN_W:0]   t;
        for (int l = 0; l < LANES; l++)
        begin
            n = force_in.num[l % 3];
            d = (l < 3) ? force_in.den_a : force_in.den_b;
            ovf_next[0][l] = (n[NUM_W-1:QUO_W] >= {1'b0, d});
            rem_next[0][l] = n[NUM_W-2:QUO_W];
            low_next[0][l] = n[QUO_W-1:0];
            quo_next[0][l] = '0;
            den_next[0][l] = d;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                t = {rem_reg[i-1][l], low_reg[i-1][l][QUO_W-1]};
                den_next[i][l] = den_reg[i-1][l];
                ovf_next[i][l] = ovf_reg[i-1][l];
                low_next[i][l] = {low_reg[i-1][l][QUO_W-2:0], 1'b0};
                if (t >= {1'b0, den_reg[i-1][l]})
                begin
                    rem_next[i][l] = DEN_W'(t - {1'b0, den_reg[i-1][l]});
                    quo_next[i][l] = {quo_reg[i-1][l][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i][l] = t[DEN_W-1:0];
                    quo_next[i][l] = {quo_reg[i-1][l][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[i][l] <= rem_next[i][l];
                low_reg[i][l] <= low_next[i][l];
                quo_reg[i][l] <= quo_next[i][l];
                den_reg[i][l] <= den_next[i][l];
                ovf_reg[i][l] <= ovf_next[i][l];
            end
            tag_reg[i] <= (i == 0) ? force_in.tag : tag_reg[i-1];
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quot.ovf[l] = ovf_reg[DIV_STAGES-1][l];
            quot.quo[l] = quo_reg[DIV_STAGES-1][l];
        end
        quot.tag = tag_reg[DIV_STAGES-1];
    end

    assign out_valid = valid_reg[DIV_STAGES-1];

endmodule

@@ design/spring_bond_force.sv @@
// top level of the Hooke spring bond force pipeline: stiffness register, stages, output register
// depends on sbf_pkg, sbf_front, sbf_sqrt, sbf_force, sbf_div
//
// channel     signals                              transaction when
// ---------   ----------------------------------   ---------------------------
// bond in     start, busy, bond                    start && !busy at clk rise
// stiffness   cfg_valid, cfg_ready, cfg_data       cfg_valid && cfg_ready
// result out  result_valid, result                 result_valid, one cycle
//
// one bond enters every cycle; busy is never raised
// each result follows its bond through the front stages, the 33-stage square root,
// the force stages, the 33-stage divider lanes and the output register
// the receiver cannot stall, so the pipeline advances every cycle
// rst_n clears the valid bits of every stage and loads a stiffness of 4.0
module spring_bond_force
    import sbf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bond_t          bond,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [K_W-1:0] cfg_data,
    output logic           result_valid,
    output result_t        result
);

    logic [K_W-1:0]    k_reg;
    logic              front_valid;
    logic [RAD_W-1:0]  front_rad;
    side_t             front_side;
    logic              sqrt_valid;
    logic [ROOT_W-1:0] sqrt_root;
    side_t             sqrt_side;
    logic              force_valid;
    force_t            force_data;
    logic              div_valid;
    quot_t             div_quot;
    logic              valid_reg;
    result_t           result_reg, result_next;

    function automatic logic [QUO_W-1:0] sat_val(input logic ovf,
                                                  input logic [QUO_W-1:0] q,
                                                  input logic neg);
        logic [QUO_W-1:0] r;
        if (!neg)
        begin
            r = (ovf || q[QUO_W-1]) ? 32'h7FFF_FFFF : q;
        end
        else
        begin
            r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : QUO_W'(-q);
        end
        return r;
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            k_reg <= cfg_data;
        end
    end

    sbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .bond      (bond),
        .out_valid (front_valid),
        .rad       (front_rad),
        .side      (front_side)
    );

    sbf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .rad       (front_rad),
        .side_in   (front_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .side_out  (sqrt_side)
    );

    sbf_force u_force (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .len       (sqrt_root),
        .side      (sqrt_side),
        .kspring   (k_reg),
        .out_valid (force_valid),
        .force_out (force_data)
    );

    sbf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (force_valid),
        .force_in  (force_data),
        .out_valid (div_valid),
        .quot      (div_quot)
    );

    always_comb
    begin
        logic [LANES-1:0][QUO_W-1:0] dv;
        logic                        neg;
        tag_t                        tg;
        tg = div_quot.tag;
        for (int l = 0; l < LANES; l++)
        begin
            neg   = tg.xneg ^ tg.dneg[l % 3] ^ (l >= 3);
            dv[l] = sat_val(div_quot.ovf[l], div_quot.quo[l], neg);
        end
        result_next.status = ST_OK;
        if (tg.zero_len)
        begin
            dv                 = '0;
            result_next.status = ST_ZERO_LEN;
        end
        else
        begin
            // pinned atoms and atoms with no mass get nothing, free atoms with no mass flag the item
            if (tg.fixed_a || tg.mass_a_zero)
            begin
                dv[0] = '0;
                dv[1] = '0;
                dv[2] = '0;
            end
            if (tg.fixed_b || tg.mass_b_zero)
            begin
                dv[3] = '0;
                dv[4] = '0;
                dv[5] = '0;
            end
            if ((!tg.fixed_a && tg.mass_a_zero) || (!tg.fixed_b && tg.mass_b_zero))
            begin
                result_next.status = ST_ZERO_MASS;
            end
        end
        result_next.dva_x = dv[0];
        result_next.dva_y = dv[1];
        result_next.dva_z = dv[2];
        result_next.dvb_x = dv[3];
        result_next.dvb_y = dv[4];
        result_next.dvb_z = dv[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT result_valid)
        else $error("transaction did not produce a result on time");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching input transaction");

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_ZERO_LEN) |->
        (result.dva_x == 0 && result.dva_y == 0 && result.dva_z == 0 &&
         result.dvb_x == 0 && result.dvb_y == 0 && result.dvb_z == 0))
        else $error("zero length bond gave nonzero increments");

endmodule
